// File: rtl/fpa_pkg.sv
// Shared constants and types for the fixed-point amount to ASCII formatter.
`default_nettype none

package fpa_pkg;

  // Input amount width and the number of decimal digits that it can need.
  localparam int AMOUNT_W    = 64;
  localparam int NUM_DIGITS  = 20;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_IDX_W = 5;

  // Number of fraction digits in the fixed-point amount.
  localparam int FRAC_DIGITS = 8;

  // Digit positions: fraction digits sit at 0 .. FRAC_DIGITS-1.
  localparam logic [DIGIT_IDX_W-1:0] INT_LOW_IDX  = DIGIT_IDX_W'(FRAC_DIGITS);
  localparam logic [DIGIT_IDX_W-1:0] INT_TOP_IDX  = DIGIT_IDX_W'(NUM_DIGITS - 1);
  localparam logic [DIGIT_IDX_W-1:0] FRAC_TOP_IDX = DIGIT_IDX_W'(FRAC_DIGITS - 1);

  // Conversion counter: one shift per amount bit.
  localparam int                    CONV_CNT_W = 6;
  localparam logic [CONV_CNT_W-1:0] CONV_LAST  = CONV_CNT_W'(AMOUNT_W - 1);

  // Ticker settings.
  localparam int                     CHAR_W     = 8;
  localparam int                     TICK_IDX_W = 4;
  localparam int                     TICK_SEL_W = 3;
  localparam logic [TICK_IDX_W-1:0]  MAX_TICKER = TICK_IDX_W'(8);
  localparam logic [TICK_SEL_W-1:0]  TICK_SEL_TOP = TICK_SEL_W'(7);

  // Characters.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  // Configuration register indexes.
  localparam int                     CFG_INDEX_W       = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKER_TEXT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKER_LENGTH = 2'd1;

  // Control that the sequencer hands to the digit chain.
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/fpa_digit_cell.sv
// One BCD digit cell of the shift-and-add-3 binary to decimal chain.
`default_nettype none

module fpa_digit_cell (
  input  wire                        clk,
  input  fpa_pkg::chain_ctrl_t       ctrl,
  input  wire                        carry_in,
  output logic                       carry_out,
  output logic [fpa_pkg::DIGIT_W-1:0] digit,
  output logic                       nz
);

  logic [fpa_pkg::DIGIT_W-1:0] adj;

  // Add three to digits of five or more so the shift carries in decimal.
  always_comb begin
    adj = (digit >= fpa_pkg::DIGIT_W'(5)) ? digit + fpa_pkg::DIGIT_W'(3) : digit;
  end

  assign carry_out = adj[fpa_pkg::DIGIT_W-1];
  assign nz        = (digit != '0);

  // Shift the adjusted digit up by one and take the neighbor's bit.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= {adj[fpa_pkg::DIGIT_W-2:0], carry_in};
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpa_bcd_chain.sv
// Row of BCD digit cells that turns the shifted-in amount into decimal digits.
`default_nettype none

module fpa_bcd_chain (
  input  wire                         clk,
  input  fpa_pkg::chain_ctrl_t        ctrl,
  output logic [fpa_pkg::DIGIT_W-1:0] digits [fpa_pkg::NUM_DIGITS],
  output logic [fpa_pkg::NUM_DIGITS-1:0] nz
);

  logic carry [fpa_pkg::NUM_DIGITS];

  // Cell zero takes the amount bit; each other cell takes its lower neighbor's carry.
  for (genvar i = 0; i < fpa_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      fpa_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (ctrl.bit_in),
        .carry_out (carry[i]),
        .digit     (digits[i]),
        .nz        (nz[i])
      );
    end else begin : g_rest
      fpa_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i-1]),
        .carry_out (carry[i]),
        .digit     (digits[i]),
        .nz        (nz[i])
      );
    end
  end

endmodule

`default_nettype wire

// File: rtl/fixed_point_amount_to_ascii.sv
// Top level: formats a fixed-point amount as ticker, space and decimal text.
//
//   Input channel (in_valid, in_stall, amount): one request is one 64-bit
//   amount counted in units of 10^-8, taken when in_valid is high and
//   in_stall is low. The block works on one amount at a time.
//   Output channel (out_valid, out_stall, out_char, last): one ASCII
//   character per transfer, in text order; last marks the final character.
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 sets
//   the ticker text, index 1 the ticker length; cfg_ready is always high.
//   The amount is converted by shifting its 64 bits through a row of 20 BCD
//   digit cells. The text then leaves at one character per cycle while the
//   output does not stall; the sequencer also closes the ticker and skips
//   the leading zeros of the integral part (at most 11) without a character.
//   The next amount is taken as soon as the last character sits in the
//   output register. Reset empties the output register, clears both
//   configuration registers and idles the sequencer. A stalled character
//   holds on the output and the sequencer waits with it before putting out
//   its next character.
`default_nettype none

module fixed_point_amount_to_ascii (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [fpa_pkg::AMOUNT_W-1:0]     amount,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [fpa_pkg::CHAR_W-1:0]       out_char,
  output logic                             last,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [fpa_pkg::AMOUNT_W-1:0]     cfg_data
);

  localparam int              STATE_W  = 3;
  localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] ST_CONV  = 3'd1;
  localparam logic [STATE_W-1:0] ST_TICK  = 3'd2;
  localparam logic [STATE_W-1:0] ST_SPACE = 3'd3;
  localparam logic [STATE_W-1:0] ST_SKIP  = 3'd4;
  localparam logic [STATE_W-1:0] ST_INT   = 3'd5;
  localparam logic [STATE_W-1:0] ST_DOT   = 3'd6;
  localparam logic [STATE_W-1:0] ST_FRAC  = 3'd7;

  logic [STATE_W-1:0]                   state;
  logic [fpa_pkg::AMOUNT_W-1:0]         amt;
  logic [fpa_pkg::CONV_CNT_W-1:0]       conv_cnt;
  logic [fpa_pkg::TICK_IDX_W-1:0]       tick_idx;
  logic [fpa_pkg::DIGIT_IDX_W-1:0]      dig_idx;
  logic [fpa_pkg::AMOUNT_W-1:0]         ticker_text;
  logic [fpa_pkg::TICK_IDX_W-1:0]       ticker_length;

  logic [fpa_pkg::TICK_IDX_W-1:0]       len_sat;
  logic [fpa_pkg::TICK_SEL_W-1:0]       byte_sel;
  logic [fpa_pkg::CHAR_W-1:0]           tick_byte;
  logic [fpa_pkg::DIGIT_W-1:0]          digits [fpa_pkg::NUM_DIGITS];
  logic [fpa_pkg::NUM_DIGITS-1:0]       nz;
  logic [fpa_pkg::DIGIT_W-1:0]          cur_digit;
  logic                                 frac_nz;
  logic                                 below_nz;
  logic                                 accept;
  logic                                 out_free;
  logic                                 emit;
  logic [fpa_pkg::CHAR_W-1:0]           emit_char;
  logic                                 emit_last;
  fpa_pkg::chain_ctrl_t                 chain_ctrl;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Digit chain: cleared on a new request, shifted once per amount bit.
  assign chain_ctrl.clear  = accept;
  assign chain_ctrl.shift  = (state == ST_CONV);
  assign chain_ctrl.bit_in = amt[fpa_pkg::AMOUNT_W-1];

  fpa_bcd_chain u_chain (
    .clk    (clk),
    .ctrl   (chain_ctrl),
    .digits (digits),
    .nz     (nz)
  );

  // Ticker length saturates at eight characters.
  assign len_sat   = (ticker_length > fpa_pkg::MAX_TICKER) ? fpa_pkg::MAX_TICKER
                                                          : ticker_length;
  assign byte_sel  = fpa_pkg::TICK_SEL_TOP - tick_idx[fpa_pkg::TICK_SEL_W-1:0];
  assign tick_byte = ticker_text[{byte_sel, 3'b000} +: fpa_pkg::CHAR_W];

  // Digit under the read pointer and the fraction's nonzero flags.
  assign cur_digit = digits[dig_idx];
  assign frac_nz   = |nz[fpa_pkg::FRAC_DIGITS-1:0];

  // A fraction digit is the last one when no nonzero digit sits below it.
  always_comb begin
    below_nz = 1'b0;
    for (int j = 0; j < fpa_pkg::FRAC_DIGITS; j++) begin
      if (nz[j] && (fpa_pkg::DIGIT_IDX_W'(j) < dig_idx)) begin
        below_nz = 1'b1;
      end
    end
  end

  // Character that the current state puts into the output register.
  always_comb begin
    emit      = 1'b0;
    emit_char = fpa_pkg::CHAR_SPACE;
    emit_last = 1'b0;
    unique case (state)
      ST_TICK: begin
        if (tick_idx < len_sat) begin
          emit      = out_free;
          emit_char = tick_byte;
        end
      end
      ST_SPACE: begin
        emit      = out_free;
        emit_char = fpa_pkg::CHAR_SPACE;
      end
      ST_INT: begin
        emit      = out_free;
        emit_char = fpa_pkg::CHAR_ZERO + fpa_pkg::CHAR_W'(cur_digit);
        emit_last = !frac_nz && (dig_idx == fpa_pkg::INT_LOW_IDX);
      end
      ST_DOT: begin
        emit      = out_free;
        emit_char = fpa_pkg::CHAR_DOT;
      end
      ST_FRAC: begin
        emit      = out_free;
        emit_char = fpa_pkg::CHAR_ZERO + fpa_pkg::CHAR_W'(cur_digit);
        emit_last = !below_nz;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: convert, then walk ticker, space, integral part, and dot and fraction when the fraction is nonzero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            amt      <= amount;
            conv_cnt <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          amt      <= {amt[fpa_pkg::AMOUNT_W-2:0], 1'b0};
          conv_cnt <= conv_cnt + fpa_pkg::CONV_CNT_W'(1);
          if (conv_cnt == fpa_pkg::CONV_LAST) begin
            tick_idx <= '0;
            state    <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (tick_idx >= len_sat) begin
            state <= ST_SPACE;
          end else if (out_free) begin
            tick_idx <= tick_idx + fpa_pkg::TICK_IDX_W'(1);
          end
        end
        ST_SPACE: begin
          if (out_free) begin
            dig_idx <= fpa_pkg::INT_TOP_IDX;
            state   <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if ((dig_idx > fpa_pkg::INT_LOW_IDX) && (cur_digit == '0)) begin
            dig_idx <= dig_idx - fpa_pkg::DIGIT_IDX_W'(1);
          end else begin
            state <= ST_INT;
          end
        end
        ST_INT: begin
          if (out_free) begin
            if (dig_idx == fpa_pkg::INT_LOW_IDX) begin
              state <= frac_nz ? ST_DOT : ST_IDLE;
            end else begin
              dig_idx <= dig_idx - fpa_pkg::DIGIT_IDX_W'(1);
            end
          end
        end
        ST_DOT: begin
          if (out_free) begin
            dig_idx <= fpa_pkg::FRAC_TOP_IDX;
            state   <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (out_free) begin
            if (!below_nz) begin
              state <= ST_IDLE;
            end else begin
              dig_idx <= dig_idx - fpa_pkg::DIGIT_IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a character until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      last     <= emit_last;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticker_text   <= '0;
      ticker_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpa_pkg::REG_TICKER_TEXT: begin
          ticker_text <= cfg_data;
        end
        fpa_pkg::REG_TICKER_LENGTH: begin
          ticker_length <= cfg_data[fpa_pkg::TICK_IDX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpa_checker.sv
// Port-level checker for the amount formatter, bound to the top level.
`default_nettype none

module fpa_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [fpa_pkg::CHAR_W-1:0]       out_char,
  input wire                             last,
  input wire                             cfg_ready
);

  // A stalled character and its last flag hold.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled output changed");

  // A taken request keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without going busy");

  // While a character other than the final one is on the output, no new request is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("request taken in the middle of a text");

  // After the final character leaves, nothing follows at once.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("character right after end of text");

  // The configuration port always takes writes.
  assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind fixed_point_amount_to_ascii fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .last      (last),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
